>>> hdl/clc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clc_pkg : shared definitions for the complex linear convolver
// Sizes, word layouts and the control group that runs along the tap chain.
// ----------------------------------------------------------------------------
package clc_pkg;

   // Number of cells in the tap chain.
   localparam int MAX_TAPS    = 16;

   // Field widths fixed by the word layouts.
   localparam int SAMPLE_W    = 16;
   localparam int IDX_W       = 4;
   localparam int TAP_CNT_W   = 5;
   localparam int PROD_W      = 2 * SAMPLE_W + 1;
   localparam int ACC_W       = 39;

   // Word widths, padded to whole bytes.
   localparam int REQ_DATA_W  = IDX_W + 2 * SAMPLE_W;
   localparam int REQ_TDATA_W = ((REQ_DATA_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = 2 * ACC_W;
   localparam int RSP_TDATA_W = ((RSP_DATA_W + 7) / 8) * 8;

   // The products are formed first, then the sum wave runs along every cell.
   localparam int SUM_CYCLES  = MAX_TAPS + 1;
   localparam int SUM_CNT_W   = $clog2(SUM_CYCLES);
   localparam int TAIL_W      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

   typedef enum logic {
      REQ_TAP    = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage
`default_nettype wire

>>> hdl/clc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clc_cell : one tap of the convolver chain
// Holds one coefficient and one delay element, forms the complex product and
// adds it to the partial sum handed on by the previous cell.
// ----------------------------------------------------------------------------
module clc_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  clc_pkg::cell_ctrl_type                 ctrl,
   input  logic                                   coef_we,
   input  logic                                   tap_en,
   input  logic signed [clc_pkg::SAMPLE_W-1:0]    coef_re,
   input  logic signed [clc_pkg::SAMPLE_W-1:0]    coef_im,
   input  logic signed [clc_pkg::SAMPLE_W-1:0]    x_re_prev,
   input  logic signed [clc_pkg::SAMPLE_W-1:0]    x_im_prev,
   input  logic signed [clc_pkg::ACC_W-1:0]       psum_re_prev,
   input  logic signed [clc_pkg::ACC_W-1:0]       psum_im_prev,
   output logic signed [clc_pkg::SAMPLE_W-1:0]    x_re,
   output logic signed [clc_pkg::SAMPLE_W-1:0]    x_im,
   output logic signed [clc_pkg::ACC_W-1:0]       psum_re,
   output logic signed [clc_pkg::ACC_W-1:0]       psum_im
);

   logic signed [clc_pkg::SAMPLE_W-1:0]   coef_re_ff, coef_im_ff;
   logic signed [clc_pkg::SAMPLE_W-1:0]   x_re_ff, x_im_ff;
   logic signed [clc_pkg::PROD_W-1:0]     prod_re_ff, prod_im_ff;
   logic signed [clc_pkg::PROD_W-1:0]     prod_re_in, prod_im_in;
   logic signed [clc_pkg::ACC_W-1:0]      psum_re_ff, psum_im_ff;
   logic signed [clc_pkg::ACC_W-1:0]      psum_re_in, psum_im_in;
   logic signed [2*clc_pkg::SAMPLE_W-1:0] p_rr, p_ii, p_ri, p_ir;

   assign p_rr = coef_re_ff * x_re_ff;
   assign p_ii = coef_im_ff * x_im_ff;
   assign p_ri = coef_re_ff * x_im_ff;
   assign p_ir = coef_im_ff * x_re_ff;

   // Taps beyond the count in use contribute nothing.
   always_comb begin
      if (tap_en) begin
         prod_re_in = clc_pkg::PROD_W'(p_rr) - clc_pkg::PROD_W'(p_ii);
         prod_im_in = clc_pkg::PROD_W'(p_ri) + clc_pkg::PROD_W'(p_ir);
      end else begin
         prod_re_in = '0;
         prod_im_in = '0;
      end
   end

   assign psum_re_in = psum_re_prev + clc_pkg::ACC_W'(prod_re_ff);
   assign psum_im_in = psum_im_prev + clc_pkg::ACC_W'(prod_im_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_re_ff <= '0;
         x_im_ff <= '0;
      end else if (ctrl.clear) begin
         x_re_ff <= '0;
         x_im_ff <= '0;
      end else if (ctrl.shift) begin
         x_re_ff <= x_re_prev;
         x_im_ff <= x_im_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_re_ff <= coef_re;
         coef_im_ff <= coef_im;
      end
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
      psum_re_ff <= psum_re_in;
      psum_im_ff <= psum_im_in;
   end

   assign x_re    = x_re_ff;
   assign x_im    = x_im_ff;
   assign psum_re = psum_re_ff;
   assign psum_im = psum_im_ff;

endmodule
`default_nettype wire

>>> hdl/complex_linear_convolver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// complex_linear_convolver_top : complex FIR with full linear convolution
// Loads complex taps, shifts complex samples through a chain of tap cells and
// returns one full-precision output per sample, plus the tail after a frame.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents (lowest bit first)
//  --------  ---------  ---------------------------------------------------
//  req_*     in         tdata: tap_index, value_re, value_im; tuser: req_type;
//                       tlast: frame_end
//  rsp_*     out        tdata: y_re, y_im; tlast: last_out
//  csr_*     in         wdata: tap_count, written whenever csr_we is high
//
// When the delay line shifts, the products are formed in every cell, then the
// partial sum moves one cell per cycle; the output is offered once the sum wave
// has passed the last cell. req_tready stays low from a sample's acceptance
// until its last word, tail included, is taken, so a stall on rsp_tready
// stalls the input. Synchronous reset clears the delay line and sets the tap
// count to one; coefficients are not cleared and must be loaded first.
//
module complex_linear_convolver_top (
   input  logic                               clock,
   input  logic                               reset,
   // Input words
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tap_index [3:0], value_re [19:4], value_im [35:20], zero fill above
   input  logic [clc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_type [0]
   input  logic                               req_tuser,
   input  logic                               req_tlast,
   // Result words
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // y_re [38:0], y_im [77:39], zero fill above
   output logic [clc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   // Configuration
   input  logic                               csr_we,
   input  logic [clc_pkg::TAP_CNT_W-1:0]      csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SUM,
      S_OUT
   } state_type;

   state_type                             state_ff;
   logic [clc_pkg::SUM_CNT_W-1:0]         cnt_ff;
   logic [clc_pkg::TAIL_W-1:0]            tail_ff;
   logic                                  frame_ff;
   logic [clc_pkg::TAP_CNT_W-1:0]         tap_count_ff;
   logic [clc_pkg::TAP_CNT_W-1:0]         taps_eff;

   logic                                  req_acc, rsp_acc;
   logic                                  is_sample;
   logic [clc_pkg::IDX_W-1:0]             req_idx;
   logic signed [clc_pkg::SAMPLE_W-1:0]   req_re, req_im;
   logic signed [clc_pkg::SAMPLE_W-1:0]   shift_re, shift_im;
   clc_pkg::cell_ctrl_type                ctrl;
   logic [clc_pkg::MAX_TAPS-1:0]          coef_we, tap_en;

   // Chain links: entry k feeds cell k, entry k+1 is what cell k hands on.
   logic signed [clc_pkg::SAMPLE_W-1:0]   x_re_chain   [clc_pkg::MAX_TAPS+1];
   logic signed [clc_pkg::SAMPLE_W-1:0]   x_im_chain   [clc_pkg::MAX_TAPS+1];
   logic signed [clc_pkg::ACC_W-1:0]      psum_re_chain [clc_pkg::MAX_TAPS+1];
   logic signed [clc_pkg::ACC_W-1:0]      psum_im_chain [clc_pkg::MAX_TAPS+1];

   assign req_idx = req_tdata[clc_pkg::IDX_W-1:0];
   assign req_re  = req_tdata[clc_pkg::IDX_W +: clc_pkg::SAMPLE_W];
   assign req_im  = req_tdata[clc_pkg::IDX_W + clc_pkg::SAMPLE_W +: clc_pkg::SAMPLE_W];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign is_sample  = (req_tuser == clc_pkg::REQ_SAMPLE);

   // A count above the chain length behaves as the full chain.
   assign taps_eff = (tap_count_ff > clc_pkg::TAP_CNT_W'(clc_pkg::MAX_TAPS)) ?
                     clc_pkg::TAP_CNT_W'(clc_pkg::MAX_TAPS) : tap_count_ff;

   // New samples enter from the request; tail outputs are fed with zeros.
   assign shift_re = (state_ff == S_IDLE) ? req_re : '0;
   assign shift_im = (state_ff == S_IDLE) ? req_im : '0;

   always_comb begin
      ctrl.shift = (req_acc && is_sample) ||
                   (rsp_acc && frame_ff && (tail_ff != '0));
      // The delay line is emptied once a frame's results are all delivered,
      // or at once when a frame ends with no taps in use.
      ctrl.clear = (rsp_acc && frame_ff && (tail_ff == '0)) ||
                   (req_acc && is_sample && req_tlast && (taps_eff == '0));
   end

   assign x_re_chain[0]    = shift_re;
   assign x_im_chain[0]    = shift_im;
   assign psum_re_chain[0] = '0;
   assign psum_im_chain[0] = '0;

   for (genvar k = 0; k < clc_pkg::MAX_TAPS; k++) begin : g_cell
      assign coef_we[k] = req_acc && !is_sample && (32'(req_idx) == k);
      assign tap_en[k]  = (32'(taps_eff) > k);

      clc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .coef_we      (coef_we[k]),
         .tap_en       (tap_en[k]),
         .coef_re      (req_re),
         .coef_im      (req_im),
         .x_re_prev    (x_re_chain[k]),
         .x_im_prev    (x_im_chain[k]),
         .psum_re_prev (psum_re_chain[k]),
         .psum_im_prev (psum_im_chain[k]),
         .x_re         (x_re_chain[k+1]),
         .x_im         (x_im_chain[k+1]),
         .psum_re      (psum_re_chain[k+1]),
         .psum_im      (psum_im_chain[k+1])
      );
   end

   // Sequencer. The last cell's sum register is the output register: it
   // stays put while the word is offered because the delay line is frozen.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         tail_ff      <= '0;
         frame_ff     <= 1'b0;
         tap_count_ff <= clc_pkg::TAP_CNT_W'(1);
      end else begin
         if (csr_we) begin
            tap_count_ff <= csr_wdata;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc && is_sample && (taps_eff != '0)) begin
                  state_ff <= S_SUM;
                  cnt_ff   <= '0;
                  frame_ff <= req_tlast;
                  tail_ff  <= clc_pkg::TAIL_W'(taps_eff - clc_pkg::TAP_CNT_W'(1));
               end
            end
            S_SUM: begin
               if (cnt_ff == clc_pkg::SUM_CNT_W'(clc_pkg::SUM_CYCLES - 1)) begin
                  state_ff <= S_OUT;
               end else begin
                  cnt_ff <= cnt_ff + clc_pkg::SUM_CNT_W'(1);
               end
            end
            S_OUT: begin
               if (rsp_acc) begin
                  if (frame_ff && (tail_ff != '0)) begin
                     tail_ff  <= tail_ff - clc_pkg::TAIL_W'(1);
                     cnt_ff   <= '0;
                     state_ff <= S_SUM;
                  end else begin
                     frame_ff <= 1'b0;
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tdata = {{(clc_pkg::RSP_TDATA_W - clc_pkg::RSP_DATA_W){1'b0}},
                       psum_im_chain[clc_pkg::MAX_TAPS],
                       psum_re_chain[clc_pkg::MAX_TAPS]};
   assign rsp_tlast = frame_ff && (tail_ff == '0);

   // The block never offers a result while it is open for input.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("result offered while input is accepted");

   // A result is only offered once the sum wave has run its full course.
   a_sum_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == S_SUM) &&
                            ($past(cnt_ff) == clc_pkg::SUM_CNT_W'(clc_pkg::SUM_CYCLES - 1)))
      else $error("result offered before the sum was complete");

   // Delivering the last word of a frame empties the delay line.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=>
         (x_re_chain[1] == '0) && (x_im_chain[1] == '0) &&
         (x_re_chain[clc_pkg::MAX_TAPS] == '0))
      else $error("delay line not cleared at the end of a frame");

   // The delay line moves only on an accepted sample or a tail step.
   a_shift_cause: assert property (@(posedge clock) disable iff (reset)
      ctrl.shift |-> (req_acc && is_sample) || (rsp_acc && frame_ff))
      else $error("delay line shifted without cause");

endmodule
`default_nettype wire
